// File: rtl/core/cdlh_pkg.sv
// ----------------------------------------------------------------------------
// cdlh_pkg: shared types and constants of the clip detector
// Register indexes, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package cdlh_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ENABLED   = 3'd0;
   localparam logic [2:0] CSR_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_STRIDE    = 3'd2;
   localparam logic [2:0] CSR_TRIGGER   = 3'd3;
   localparam logic [2:0] CSR_WINDOW    = 3'd4;
   localparam logic [2:0] CSR_HOLD      = 3'd5;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 32;
   localparam int THRESH_W  = 31;
   localparam int STRIDE_W  = 8;
   localparam int TRIGGER_W = 16;
   localparam int WINDOW_W  = 24;
   localparam int HOLD_W    = 24;
   localparam int ELAPSED_W = 16;
   localparam int PENDING_W = 32;
   localparam int PROD_W    = TRIGGER_W + ELAPSED_W;
   localparam int CSR_DATA_W = 32;

   // Input kinds carried in the mode field.
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_ADD   = 7'b0010000,
      ST_HOLD  = 7'b0100000,
      ST_SEND  = 7'b1000000
   } state_type;

endpackage

// File: rtl/core/clip_detector_leaky_hold.sv
// ----------------------------------------------------------------------------
// clip_detector_leaky_hold: clip indicator with leaky-bucket credit and hold
// Probes float samples against a threshold and lights an indicator on ticks.
// ----------------------------------------------------------------------------
// Usage. Items enter on the req_ stream. A sample transaction (req_tuser[0]
// low) is probed in the cycle it is accepted and produces no result. A tick
// transaction (req_tuser[0] high) drains the credit by
// trigger*elapsed/window, adds the pending hits, caps the credit, updates
// the hold timer and returns one result transaction on the rsp_ stream.
// Samples can be accepted one per cycle while no tick is in progress. An
// enabled tick steps through multiply, divide, drain, add, hold and send
// before the result is offered and the block is ready again; the restoring
// divider retires one quotient bit per cycle over a numerator of
// 32 + CREDIT_FRAC_BITS bits. A disabled tick goes straight to send.
// The result sits in an output register, so further samples are accepted
// while it waits for rsp_tready; a second tick waits in its last step until
// the output register is free. The csr_ channel is always ready; writing
// the enable register clears credit, hold timer, pending hits and phase.
// Reset restores the register defaults and clears all activity state.
// ----------------------------------------------------------------------------
module clip_detector_leaky_hold
   import cdlh_pkg::*;
#(
   parameter int CREDIT_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: sample_bits [31:0], elapsed_us [47:32]
   input  logic [47:0]            req_tdata,
   // tuser: mode [0], block_start [1]
   input  logic [1:0]             req_tuser,
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: lit [0], credit_whole [16:1], zero fill [23:17]
   output logic [23:0]            rsp_tdata,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Credit is unsigned fixed point; the cap needs the full trigger width.
   localparam int CAP_W = TRIGGER_W + CREDIT_FRAC_BITS;
   // Numerator of the drain division: trigger * elapsed, scaled.
   localparam int NUM_W = PROD_W + CREDIT_FRAC_BITS;
   localparam int SUM_W = PENDING_W + CREDIT_FRAC_BITS + 1;
   localparam int CNT_W = $clog2(NUM_W);

   // Configuration registers.
   logic                 enabled_ff, enabled_in;
   logic [THRESH_W-1:0]  thresh_ff, thresh_in;
   logic [STRIDE_W-1:0]  stride_ff, stride_in;
   logic [TRIGGER_W-1:0] trigger_ff, trigger_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;
   logic [HOLD_W-1:0]    hold_us_ff, hold_us_in;

   // Activity state.
   logic [STRIDE_W-1:0]  phase_ff, phase_in;
   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic [CAP_W-1:0]     credit_ff, credit_in;
   logic [HOLD_W-1:0]    hold_left_ff, hold_left_in;
   logic                 lit_ff, lit_in;

   // Sequencer and the divider datapath.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [WINDOW_W-1:0]  rem_ff, rem_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_lit_ff, rsp_lit_in;
   logic [TRIGGER_W-1:0] rsp_whole_ff, rsp_whole_in;

   logic                 req_accept;
   logic                 req_mode;
   logic                 req_start;
   logic [SAMPLE_W-1:0]  req_sample;
   logic [ELAPSED_W-1:0] req_elapsed;
   logic [STRIDE_W-1:0]  stride_eff;
   logic [STRIDE_W:0]    phase_next;
   logic [STRIDE_W-1:0]  phase_cur;
   logic [WINDOW_W-1:0]  window_eff;
   logic [PROD_W-1:0]    product;
   logic [WINDOW_W:0]    trial;
   logic [WINDOW_W:0]    trial_diff;
   logic [CAP_W-1:0]     cap;
   logic [NUM_W-1:0]     credit_wide;
   logic [SUM_W-1:0]     sum;
   logic                 triggered;
   logic                 out_free;

   assign req_mode    = req_tuser[0];
   assign req_start   = req_tuser[1];
   assign req_sample  = req_tdata[SAMPLE_W-1:0];
   assign req_elapsed = req_tdata[SAMPLE_W +: ELAPSED_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_whole_ff, rsp_lit_ff};

   // A stride or window of zero behaves as one.
   assign stride_eff = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;
   assign window_eff = (window_ff == '0) ? WINDOW_W'(1) : window_ff;

   // A start marker restarts the probe phase before the sample is probed.
   assign phase_cur  = req_start ? '0 : phase_ff;
   assign phase_next = {1'b0, phase_cur} + (STRIDE_W + 1)'(1);

   assign product = PROD_W'(trigger_ff) * PROD_W'(elapsed_ff);

   // One restoring divide step: shift in the next numerator bit, try the window.
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, window_eff};

   assign cap         = {trigger_ff, {CREDIT_FRAC_BITS{1'b0}}};
   assign credit_wide = NUM_W'(credit_ff);
   assign sum         = {1'b0, pending_ff, {CREDIT_FRAC_BITS{1'b0}}} + SUM_W'(credit_ff);
   assign triggered   = (credit_ff == cap);
   assign out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      enabled_in   = enabled_ff;
      thresh_in    = thresh_ff;
      stride_in    = stride_ff;
      trigger_in   = trigger_ff;
      window_in    = window_ff;
      hold_us_in   = hold_us_ff;
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      credit_in    = credit_ff;
      hold_left_in = hold_left_ff;
      lit_in       = lit_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      elapsed_in   = elapsed_ff;
      rsp_lit_in   = rsp_lit_ff;
      rsp_whole_in = rsp_whole_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_SAMPLE) begin
                  if (enabled_ff) begin
                     if (phase_cur == '0 && req_sample[THRESH_W-1:0] >= thresh_ff) begin
                        pending_in = pending_ff + PENDING_W'(stride_eff);
                     end
                     phase_in = (phase_next >= {1'b0, stride_eff}) ? '0
                                                                   : phase_next[STRIDE_W-1:0];
                  end
               end else begin
                  elapsed_in = req_elapsed;
                  state_in   = enabled_ff ? ST_MUL : ST_SEND;
               end
            end
         end
         ST_MUL: begin
            num_in   = {product, {CREDIT_FRAC_BITS{1'b0}}};
            rem_in   = '0;
            cnt_in   = CNT_W'(NUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // The numerator register fills with quotient bits from the bottom.
            if (!trial_diff[WINDOW_W]) begin
               rem_in = trial_diff[WINDOW_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[WINDOW_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Drain saturates at zero; the result never exceeds the old credit.
            credit_in = (credit_wide > num_ff) ? CAP_W'(credit_wide - num_ff) : '0;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            credit_in  = (sum > SUM_W'(cap)) ? cap : CAP_W'(sum);
            pending_in = '0;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            if (triggered) begin
               hold_left_in = hold_us_ff;
            end else if (hold_left_ff > HOLD_W'(elapsed_ff)) begin
               hold_left_in = hold_left_ff - HOLD_W'(elapsed_ff);
            end else begin
               hold_left_in = '0;
            end
            lit_in   = triggered || (hold_left_in != '0);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lit_in   = enabled_ff && lit_ff;
               rsp_whole_in = credit_ff[CAP_W-1:CREDIT_FRAC_BITS];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLED: begin
               enabled_in   = csr_data[0];
               phase_in     = '0;
               pending_in   = '0;
               credit_in    = '0;
               hold_left_in = '0;
               lit_in       = 1'b0;
            end
            CSR_THRESHOLD: thresh_in  = csr_data[THRESH_W-1:0];
            CSR_STRIDE:    stride_in  = csr_data[STRIDE_W-1:0];
            CSR_TRIGGER:   trigger_in = csr_data[TRIGGER_W-1:0];
            CSR_WINDOW:    window_in  = csr_data[WINDOW_W-1:0];
            CSR_HOLD:      hold_us_in = csr_data[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         thresh_ff    <= THRESH_W'(32'h3F80_0000);
         stride_ff    <= STRIDE_W'(1);
         trigger_ff   <= TRIGGER_W'(1);
         window_ff    <= WINDOW_W'(100000);
         hold_us_ff   <= HOLD_W'(500000);
         phase_ff     <= '0;
         pending_ff   <= '0;
         credit_ff    <= '0;
         hold_left_ff <= '0;
         lit_ff       <= 1'b0;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         thresh_ff    <= thresh_in;
         stride_ff    <= stride_in;
         trigger_ff   <= trigger_in;
         window_ff    <= window_in;
         hold_us_ff   <= hold_us_in;
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         credit_ff    <= credit_in;
         hold_left_ff <= hold_left_in;
         lit_ff       <= lit_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      elapsed_ff   <= elapsed_in;
      rsp_lit_ff   <= rsp_lit_in;
      rsp_whole_ff <= rsp_whole_in;
   end

endmodule
